>>> hw/rtl/dtt_pkg.sv
package dtt_pkg;

	localparam int TIME_W = 40;
	localparam int ID_W = 32;
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W = $clog2(MAX_RESULTS);

	localparam logic [1:0] CMD_ARM = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	typedef enum logic [2:0] {
		ST_ARMED = 3'd0,
		ST_FULL = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EXPIRED = 3'd4,
		ST_NONE = 3'd5,
		ST_IGNORED = 3'd6
	} status_t;

	typedef struct packed {
		logic valid;
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0] owner;
	} entry_t;

	localparam entry_t ENTRY_NONE = '{valid: 1'b0, deadline: '0, owner: '0};

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_mode_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_mode_t mode;
		logic [TIME_W-1:0] key_deadline;
		logic [ID_W-1:0] key_owner;
		logic [TIME_W-1:0] now;
	} cell_ctl_t;

endpackage

>>> hw/rtl/dtt_if.sv
interface dtt_req_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [31:0] id;
	logic [31:0] timeout;

	modport source (output valid, output command, output id, output timeout, input ready);
	modport sink (input valid, input command, input id, input timeout, output ready);
endinterface

interface dtt_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [31:0] expired_id;
	logic last;

	modport source (output valid, output status, output expired_id, output last, input ready);
	modport sink (input valid, input status, input expired_id, input last, output ready);
endinterface

>>> hw/rtl/dtt_cell.sv
module dtt_cell (
	input logic clk,
	input logic arst_n,
	input dtt_pkg::cell_ctl_t ctl,
	input dtt_pkg::entry_t left_entry,
	input logic left_take,
	input logic left_rm,
	input dtt_pkg::entry_t right_entry,
	output dtt_pkg::entry_t entry,
	output logic take,
	output logic rm,
	output logic due
);
	import dtt_pkg::*;

	logic valid_q;
	logic [TIME_W-1:0] deadline_q;
	logic [ID_W-1:0] owner_q;
	logic match;

	assign entry = '{valid: valid_q, deadline: deadline_q, owner: owner_q};

	// first slot past the new deadline, or the first empty slot
	assign take = !valid_q || (deadline_q > ctl.key_deadline);
	assign match = valid_q && (owner_q == ctl.key_owner);
	// removal point and everything behind it moves one slot forward
	assign rm = left_rm || match;
	assign due = valid_q && (deadline_q <= ctl.now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.mode)
				CELL_INSERT: begin
					if (left_take) begin
						valid_q <= left_entry.valid;
					end else if (take) begin
						valid_q <= 1'b1;
					end
				end
				CELL_REMOVE: begin
					if (rm) begin
						valid_q <= right_entry.valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.mode)
			CELL_INSERT: begin
				if (left_take) begin
					deadline_q <= left_entry.deadline;
					owner_q <= left_entry.owner;
				end else if (take) begin
					deadline_q <= ctl.key_deadline;
					owner_q <= ctl.key_owner;
				end
			end
			CELL_REMOVE: begin
				if (rm) begin
					deadline_q <= right_entry.deadline;
					owner_q <= right_entry.owner;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/deadline_timeout_table_unit.sv
// Deadline-ordered watchdog timeout table.
// req channel carries command (arm, cancel, tick), id and timeout; rsp channel
// returns status, expired_id and last, with last set on the final result of
// each request. Both channels use valid/ready; a transfer happens when both
// are high.
// Entries sit in a row of cells kept sorted by deadline, ties in arrival
// order. Arm inserts by shifting the tail of the row back one cell, cancel and
// expiry pop shift it forward one cell.
// A request is taken in idle into the state and operand registers; its results
// are then registered on rsp. Arm, cancel and ignored requests give one result
// each. A tick gives one result per expired entry (at most 16), or one if none
// expire; each expiry is one cell-row shift per cycle while rsp is not stalled.
// req.ready is high only between requests; the rsp output register lets a
// new request be taken while the previous result still waits.
// When the receiver stalls, the result holds on rsp and the row of cells
// stops shifting until the result is taken.
// Reset clears the time counter and all cell valid bits; the table is empty
// and ready on the first cycle after reset.
module deadline_timeout_table_unit #(
	parameter int CAPACITY = 16
) (
	input logic clk,
	input logic arst_n,
	dtt_req_if.sink req,
	dtt_rsp_if.source rsp
);
	import dtt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ARM,
		S_CANCEL,
		S_TICK,
		S_IGNORE
	} state_t;

	state_t state_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] deadline_q;
	logic [ID_W-1:0] id_q;
	logic [RES_CNT_W-1:0] count_q;

	logic rsp_valid_q;
	status_t status_q;
	logic [ID_W-1:0] expired_id_q;
	logic last_q;

	logic req_fire;
	logic slot_free;
	logic rsp_load;
	logic [TIME_W:0] sum;
	cell_ctl_t ctl;

	entry_t ent [CAPACITY];
	logic [CAPACITY-1:0] take;
	logic [CAPACITY-1:0] rm;
	logic [CAPACITY-1:0] due;
	logic due_next;
	logic full;
	logic found;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	// every busy state registers one result per free output slot
	assign rsp_load = slot_free && (state_q != S_IDLE);

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.expired_id = expired_id_q;
	assign rsp.last = last_q;

	assign sum = {1'b0, now_q} + {{(TIME_W + 1 - ID_W){1'b0}}, req.timeout};
	assign full = ent[CAPACITY-1].valid;
	assign found = rm[CAPACITY-1];

	always_comb begin
		ctl.mode = CELL_HOLD;
		ctl.key_deadline = deadline_q;
		ctl.key_owner = id_q;
		ctl.now = now_q;
		if (slot_free) begin
			case (state_q)
				S_ARM: if (!full) ctl.mode = CELL_INSERT;
				S_CANCEL: if (found) ctl.mode = CELL_REMOVE;
				S_TICK: if (due[0]) ctl.mode = CELL_REMOVE;
				default: ctl.mode = CELL_HOLD;
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic left_t;
		logic left_r;

		if (i == 0) begin : g_head
			assign left_e = ENTRY_NONE;
			assign left_t = 1'b0;
			// expiry pops the head; cancel starts the search clean
			assign left_r = (state_q == S_TICK);
		end else begin : g_body
			assign left_e = ent[i-1];
			assign left_t = take[i-1];
			assign left_r = rm[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = ENTRY_NONE;
		end else begin : g_mid
			assign right_e = ent[i+1];
		end

		dtt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.left_entry(left_e),
			.left_take(left_t),
			.left_rm(left_r),
			.right_entry(right_e),
			.entry(ent[i]),
			.take(take[i]),
			.rm(rm[i]),
			.due(due[i])
		);
	end

	if (CAPACITY > 1) begin : g_due2
		assign due_next = due[1];
	end else begin : g_due1
		assign due_next = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q <= '0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
			status_q <= ST_NONE;
			expired_id_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						count_q <= '0;
						unique case (req.command)
							CMD_ARM: begin
								if (req.id == '0 || req.timeout == '0) state_q <= S_IGNORE;
								else state_q <= S_ARM;
							end
							CMD_CANCEL: begin
								if (req.id == '0) state_q <= S_IGNORE;
								else state_q <= S_CANCEL;
							end
							CMD_TICK: begin
								state_q <= S_TICK;
								if (now_q != {TIME_W{1'b1}}) now_q <= now_q + 1'b1;
							end
							default: state_q <= S_IGNORE;
						endcase
					end
				end
				S_ARM: begin
					if (slot_free) begin
						status_q <= full ? ST_FULL : ST_ARMED;
						expired_id_q <= id_q;
						last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CANCEL: begin
					if (slot_free) begin
						status_q <= found ? ST_CANCELLED : ST_NOT_FOUND;
						expired_id_q <= id_q;
						last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (slot_free) begin
						if (due[0]) begin
							status_q <= ST_EXPIRED;
							expired_id_q <= ent[0].owner;
							count_q <= count_q + 1'b1;
							// stop at the result cap; leftovers expire next tick
							if (!due_next || count_q == RES_CNT_W'(MAX_RESULTS - 1)) begin
								last_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								last_q <= 1'b0;
							end
						end else begin
							status_q <= ST_NONE;
							expired_id_q <= '0;
							last_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_IGNORE: begin
					if (slot_free) begin
						status_q <= ST_IGNORED;
						expired_id_q <= '0;
						last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request operands; the deadline saturates at the top of the time range
	always_ff @(posedge clk) begin
		if (req_fire) begin
			id_q <= req.id;
			deadline_q <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
		end
	end

endmodule

>>> hw/rtl/dtt_checker.sv
module dtt_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] status,
	input logic [31:0] expired_id,
	input logic last
);
	import dtt_pkg::*;

	// a stalled result holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(expired_id)
			&& $stable(last))
		else $error("rsp payload changed while stalled");

	// one request in flight at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in flight");

	// only expiries come in runs; every other result closes its request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_EXPIRED |-> last)
		else $error("non-expiry result without last");

	// empty tick results and ignored requests report a zero id
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_NONE || status == ST_IGNORED) |-> expired_id == '0)
		else $error("nonzero id on empty result");

	// the unit is never ready while a multi-result tick is still open
	a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> !req_ready)
		else $error("ready during an expiry run");

endmodule

bind deadline_timeout_table_unit dtt_checker u_dtt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.expired_id(rsp.expired_id),
	.last(rsp.last)
);
